@@ sv/utf8_to_utf16_transcoder_macros.svh @@
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder_macros.svh
// Assertion macros shared by the transcoder RTL.
// ----------------------------------------------------------------------------
`ifndef UTF8_TO_UTF16_TRANSCODER_MACROS_SVH
`define UTF8_TO_UTF16_TRANSCODER_MACROS_SVH

`ifndef SYNTHESIS
`define U8U16_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("u8u16 assertion failed");
`define U8U16_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("u8u16 assertion failed");
`else
`define U8U16_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define U8U16_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

@@ sv/u8u16_pkg.sv @@
// ----------------------------------------------------------------------------
// u8u16_pkg
// Types and constants of the UTF-8 to UTF-16 transcoder.
// ----------------------------------------------------------------------------
package u8u16_pkg;

    localparam int unsigned CP_W    = 21;
    localparam int unsigned ACC_W   = 31;
    localparam int unsigned UNIT_W  = 16;

    localparam logic [UNIT_W-1:0] HI_SURR   = 16'hD800;
    localparam logic [UNIT_W-1:0] LO_SURR   = 16'hDC00;
    localparam logic [CP_W-1:0]   SUPP_BASE = 21'h10000;

    // Completed code point handed from decoder to emitter.
    typedef struct packed {
        logic            ovr;
        logic [CP_W-1:0] cp;
    } t_event;

endpackage

@@ sv/u8u16_byte_if.sv @@
// ----------------------------------------------------------------------------
// u8u16_byte_if
// Byte request channel: valid/ready handshake carrying one UTF-8 byte.
// ----------------------------------------------------------------------------
interface u8u16_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

@@ sv/u8u16_unit_if.sv @@
// ----------------------------------------------------------------------------
// u8u16_unit_if
// Code unit request channel: valid/ready handshake carrying one UTF-16 unit.
// ----------------------------------------------------------------------------
interface u8u16_unit_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_unit;
    logic        last_unit;
    logic        overrange;

    modport source (output valid, output code_unit, output last_unit,
                    output overrange, input ready);
    modport sink   (input valid, input code_unit, input last_unit,
                    input overrange, output ready);
endinterface

@@ sv/u8u16_decoder.sv @@
// ----------------------------------------------------------------------------
// u8u16_decoder
// Sequence state, byte accumulation and registered code point events.
// ----------------------------------------------------------------------------
`include "utf8_to_utf16_transcoder_macros.svh"

module u8u16_decoder (
    input  logic               i_clk,
    input  logic               i_rst_n,
    u8u16_byte_if.sink         i_byte,
    output logic               o_ev_valid,
    output u8u16_pkg::t_event  o_ev,
    input  logic               i_ev_ready
);

    logic [2:0]                    r_pending, n_pending;
    logic [u8u16_pkg::ACC_W-1:0]   r_accum,   n_accum;
    logic                          r_ev_valid;
    u8u16_pkg::t_event             r_ev;

    logic                          acc;
    logic                          fire;
    logic [u8u16_pkg::ACC_W-1:0]   cp;
    logic [u8u16_pkg::ACC_W-1:0]   shifted;
    logic [7:0]                    b;
    logic [2:0]                    pend_dec;

    assign b            = i_byte.in_byte;
    assign i_byte.ready = !r_ev_valid || i_ev_ready;
    assign acc          = i_byte.valid && i_byte.ready;
    assign shifted      = {r_accum[u8u16_pkg::ACC_W-7:0], b[5:0]};
    assign pend_dec     = r_pending - 3'd1;

    always_comb begin
        n_pending = r_pending;
        n_accum   = r_accum;
        fire      = 1'b0;
        cp        = '0;
        if (r_pending != 3'd0) begin
            n_pending = pend_dec;
            if (pend_dec == 3'd0) begin
                fire    = 1'b1;
                cp      = shifted;
                n_accum = '0;
            end else begin
                n_accum = shifted;
            end
        end else begin
            if (b inside {[8'hFC:8'hFF]}) begin
                n_accum   = {30'd0, b[0]};
                n_pending = 3'd5;
            end else if (b inside {[8'hF8:8'hFB]}) begin
                n_accum   = {29'd0, b[1:0]};
                n_pending = 3'd4;
            end else if (b inside {[8'hF0:8'hF7]}) begin
                n_accum   = {28'd0, b[2:0]};
                n_pending = 3'd3;
            end else if (b inside {[8'hE0:8'hEF]}) begin
                n_accum   = {27'd0, b[3:0]};
                n_pending = 3'd2;
            end else if (b inside {[8'hC0:8'hDF]}) begin
                n_accum   = {26'd0, b[4:0]};
                n_pending = 3'd1;
            end else if (b inside {[8'h80:8'hBF]}) begin
                n_accum   = r_accum;
            end else begin
                fire    = 1'b1;
                cp      = {24'd0, b[6:0]};
                n_accum = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending  <= 3'd0;
            r_accum    <= '0;
            r_ev_valid <= 1'b0;
        end else begin
            if (acc) begin
                r_pending <= n_pending;
                r_accum   <= n_accum;
            end
            if (acc && fire) begin
                r_ev_valid <= 1'b1;
            end else if (i_ev_ready) begin
                r_ev_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc && fire) begin
            r_ev.cp  <= cp[u8u16_pkg::CP_W-1:0];
            // above 0x10FFFF
            r_ev.ovr <= (|cp[u8u16_pkg::ACC_W-1:u8u16_pkg::CP_W]) ||
                        (cp[20] && (|cp[19:16]));
        end
    end

    assign o_ev_valid = r_ev_valid;
    assign o_ev       = r_ev;

    `U8U16_ASSERT_IMP(a_pend_range, i_clk, i_rst_n, 1'b1, r_pending <= 3'd5)
    `U8U16_ASSERT_NXT(a_stray_drop, i_clk, i_rst_n,
        acc && r_pending == 3'd0 && b[7:6] == 2'b10,
        r_pending == 3'd0 && !(r_ev_valid && !$past(r_ev_valid)))
    `U8U16_ASSERT_NXT(a_ev_hold, i_clk, i_rst_n,
        r_ev_valid && !i_ev_ready, r_ev_valid && $stable(r_ev))

endmodule

@@ sv/u8u16_emitter.sv @@
// ----------------------------------------------------------------------------
// u8u16_emitter
// Splits code point events into UTF-16 units; holds the output register, the
// pending low surrogate and a one-event skid register.
// ----------------------------------------------------------------------------
`include "utf8_to_utf16_transcoder_macros.svh"

module u8u16_emitter (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_ev_valid,
    input  u8u16_pkg::t_event  i_ev,
    output logic               o_ev_ready,
    u8u16_unit_if.source       o_unit
);

    logic                           r_out_valid;
    logic [u8u16_pkg::UNIT_W-1:0]   r_unit;
    logic                           r_last;
    logic                           r_ovr;
    logic                           r_low_valid;
    logic [u8u16_pkg::UNIT_W-1:0]   r_low;
    logic                           r_skid_valid;
    u8u16_pkg::t_event              r_skid;

    logic [u8u16_pkg::UNIT_W-1:0]   n_unit;
    logic                           n_last;
    logic                           n_ovr;
    logic                           n_low_valid;
    logic [u8u16_pkg::UNIT_W-1:0]   n_low;

    logic                           out_free;
    logic                           core_ready;
    logic                           sel_valid;
    u8u16_pkg::t_event              sel_ev;
    logic                           load_skid;
    logic                           take;
    logic [u8u16_pkg::CP_W-1:0]     v;

    assign out_free   = !r_out_valid || o_unit.ready;
    assign core_ready = out_free && !r_low_valid;
    assign sel_valid  = r_skid_valid || i_ev_valid;
    assign sel_ev     = r_skid_valid ? r_skid : i_ev;
    assign o_ev_ready = !r_skid_valid || core_ready;
    // event parks in the skid register when the core cannot take it directly
    assign load_skid  = i_ev_valid && o_ev_ready && (r_skid_valid || !core_ready);
    assign take       = sel_valid && core_ready;
    assign v          = sel_ev.cp - u8u16_pkg::SUPP_BASE;

    always_comb begin
        n_unit      = sel_ev.cp[u8u16_pkg::UNIT_W-1:0];
        n_last      = 1'b1;
        n_ovr       = 1'b0;
        n_low_valid = 1'b0;
        n_low       = u8u16_pkg::LO_SURR | {6'd0, v[9:0]};
        if (sel_ev.ovr) begin
            n_unit = '0;
            n_ovr  = 1'b1;
        end else if (|sel_ev.cp[20:16]) begin
            n_unit      = u8u16_pkg::HI_SURR | {6'd0, v[19:10]};
            n_last      = 1'b0;
            n_low_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_low_valid <= 1'b0;
        end else if (out_free) begin
            if (r_low_valid) begin
                r_out_valid <= 1'b1;
                r_low_valid <= 1'b0;
            end else if (sel_valid) begin
                r_out_valid <= 1'b1;
                r_low_valid <= n_low_valid;
            end else begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_valid <= 1'b0;
        end else if (load_skid) begin
            r_skid_valid <= 1'b1;
        end else if (core_ready) begin
            r_skid_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_skid) begin
            r_skid <= i_ev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_low_valid) begin
            r_unit <= r_low;
            r_last <= 1'b1;
            r_ovr  <= 1'b0;
        end else if (take) begin
            r_unit <= n_unit;
            r_last <= n_last;
            r_ovr  <= n_ovr;
            r_low  <= n_low;
        end
    end

    assign o_unit.valid     = r_out_valid;
    assign o_unit.code_unit = r_unit;
    assign o_unit.last_unit = r_last;
    assign o_unit.overrange = r_ovr;

    // low half waits only behind its high half
    `U8U16_ASSERT_IMP(a_low_behind_high, i_clk, i_rst_n, r_low_valid,
        r_out_valid && !r_last)
    `U8U16_ASSERT_IMP(a_high_has_low, i_clk, i_rst_n, r_out_valid && !r_last,
        r_low_valid)
    `U8U16_ASSERT_IMP(a_ovr_zero, i_clk, i_rst_n, r_out_valid && r_ovr,
        r_unit == '0 && r_last)

endmodule

@@ sv/utf8_to_utf16_transcoder.sv @@
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder
// Streaming UTF-8 to UTF-16 transcoder, one byte in, one UTF-16 unit out.
// ----------------------------------------------------------------------------
// Accepts one UTF-8 byte per cycle on i_byte and delivers UTF-16 code units on
// o_unit. A byte that completes a code point passes through the decoder's event
// register and the emitter's output register to o_unit, and also through the
// emitter's skid register when it queues behind the low half of a surrogate
// pair; lead bytes, continuations short of the end and stray continuation bytes
// give no unit. A code point above 0xFFFF gives a high and a low surrogate,
// which occupy the output register one after the other; a one-event skid
// register in the emitter absorbs the extra unit, so the input keeps taking
// one byte per cycle and stalls only under output back pressure. Code points
// above 0x10FFFF give one unit of value zero with overrange set. Overlong forms
// and surrogate code points pass unchecked; a partial sequence stays pending
// until more bytes arrive or reset.
// ----------------------------------------------------------------------------
module utf8_to_utf16_transcoder (
    input  logic          i_clk,
    input  logic          i_rst_n,
    u8u16_byte_if.sink    i_byte,
    u8u16_unit_if.source  o_unit
);

    logic               ev_valid;
    logic               ev_ready;
    u8u16_pkg::t_event  ev;

    u8u16_decoder u_decoder (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_byte     (i_byte),
        .o_ev_valid (ev_valid),
        .o_ev       (ev),
        .i_ev_ready (ev_ready)
    );

    u8u16_emitter u_emitter (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ev_valid (ev_valid),
        .i_ev       (ev),
        .o_ev_ready (ev_ready),
        .o_unit     (o_unit)
    );

endmodule
